>>> src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");

`endif

>>> src/exptok_pkg.sv
// Types, codes and character classes for the expression tokenizer.
package exptok_pkg;

	// Token kind codes
	localparam logic [3:0] KIND_EOI     = 4'd0;
	localparam logic [3:0] KIND_UNKNOWN = 4'd1;
	localparam logic [3:0] KIND_IDENT   = 4'd2;
	localparam logic [3:0] KIND_NUMBER  = 4'd3;
	localparam logic [3:0] KIND_WITH    = 4'd4;
	localparam logic [3:0] KIND_PLUS    = 4'd5;
	localparam logic [3:0] KIND_MINUS   = 4'd6;
	localparam logic [3:0] KIND_STAR    = 4'd7;
	localparam logic [3:0] KIND_SLASH   = 4'd8;
	localparam logic [3:0] KIND_LPAREN  = 4'd9;
	localparam logic [3:0] KIND_RPAREN  = 4'd10;
	localparam logic [3:0] KIND_COLON   = 4'd11;
	localparam logic [3:0] KIND_COMMA   = 4'd12;

	// Keyword match progress
	localparam logic [2:0] KW_FULL = 3'd4;
	localparam logic [2:0] KW_DEAD = 3'd7;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

	// Pending run state
	typedef enum logic [2:0] {
		RUN_NONE   = 3'b001,
		RUN_IDENT  = 3'b010,
		RUN_NUMBER = 3'b100
	} run_mode_t;

	typedef struct packed {
		logic [3:0]  kind;
		logic [15:0] start;
		logic [7:0]  length;
	} token_t;

	// Tokens caused by one input item: an optional flushed run, then the
	// optional token of the character itself.
	typedef struct packed {
		logic   has_flush;
		token_t flush_tok;
		logic   has_cur;
		token_t cur_tok;
	} entry_t;

	// Queue status seen by the front and back
	typedef struct packed {
		logic full;
		logic valid;
	} queue_stat_t;

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	// space, tab, line feed, vertical tab, form feed, carriage return
	function automatic logic is_space(input logic [7:0] c);
		return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
	endfunction

	function automatic logic [3:0] single_kind(input logic [7:0] c);
		logic [3:0] k;
		unique case (c)
			8'h2b:   k = KIND_PLUS;
			8'h2d:   k = KIND_MINUS;
			8'h2a:   k = KIND_STAR;
			8'h2f:   k = KIND_SLASH;
			8'h28:   k = KIND_LPAREN;
			8'h29:   k = KIND_RPAREN;
			8'h3a:   k = KIND_COLON;
			8'h2c:   k = KIND_COMMA;
			default: k = KIND_UNKNOWN;
		endcase
		return k;
	endfunction

	// Letters of the keyword "with"
	function automatic logic [7:0] kw_char(input logic [2:0] idx);
		logic [7:0] ch;
		unique case (idx)
			3'd0:    ch = 8'h77;
			3'd1:    ch = 8'h69;
			3'd2:    ch = 8'h74;
			3'd3:    ch = 8'h68;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

>>> src/exptok_front.sv
// Front: accepts characters, tracks the pending run and builds token entries.
module exptok_front
	import exptok_pkg::*;
#(
	parameter int POSITION_BITS = 16,
	parameter int MAX_TOKEN_LEN = 255
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] ch
	input  queue_stat_t q_stat,
	output logic        push,
	output entry_t      push_entry
);

	localparam int LEN_BITS = $clog2(MAX_TOKEN_LEN + 1);

	logic [POSITION_BITS-1:0] position_q;
	run_mode_t                run_mode_q;
	logic [POSITION_BITS-1:0] run_start_q;
	logic [LEN_BITS-1:0]      run_len_q;
	logic [2:0]               kw_q;

	logic       accept, letter, digit, space, continues, flush, cur_valid;
	logic [7:0] c;
	logic [7:0] run_len8;

	assign c        = s_tdata;
	assign s_tready = !q_stat.full;
	assign accept   = s_tvalid && s_tready;
	assign letter   = is_letter(c);
	assign digit    = is_digit(c);
	assign space    = is_space(c);

	assign continues = (run_mode_q == RUN_IDENT && letter) ||
		(run_mode_q == RUN_NUMBER && digit);
	assign flush     = !continues && run_mode_q != RUN_NONE;
	assign cur_valid = !continues && (c == 8'h00 || (!letter && !digit && !space));

	// reported length never exceeds 255
	assign run_len8 = (32'(run_len_q) > 32'd255) ? 8'hff : 8'(run_len_q);

	// Token entry for this character
	always_comb begin
		push_entry.has_flush        = flush;
		push_entry.flush_tok.start  = 16'(run_start_q);
		push_entry.flush_tok.length = run_len8;
		if (run_mode_q == RUN_NUMBER) begin
			push_entry.flush_tok.kind = KIND_NUMBER;
		end else if (kw_q == KW_FULL) begin
			push_entry.flush_tok.kind = KIND_WITH;
		end else begin
			push_entry.flush_tok.kind = KIND_IDENT;
		end
		push_entry.has_cur       = cur_valid;
		push_entry.cur_tok.start = 16'(position_q);
		if (c == 8'h00) begin
			push_entry.cur_tok.kind   = KIND_EOI;
			push_entry.cur_tok.length = 8'd0;
		end else begin
			push_entry.cur_tok.kind   = single_kind(c);
			push_entry.cur_tok.length = 8'd1;
		end
	end

	assign push = accept && (flush || cur_valid);

	// Run and position state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q  <= '0;
			run_mode_q  <= RUN_NONE;
			run_start_q <= '0;
			run_len_q   <= '0;
			kw_q        <= '0;
		end else if (accept) begin
			if (continues) begin
				if (run_len_q < LEN_BITS'(MAX_TOKEN_LEN)) begin
					run_len_q <= run_len_q + 1'b1;
				end
				if (run_mode_q == RUN_IDENT) begin
					if (kw_q < KW_FULL && c == kw_char(kw_q)) begin
						kw_q <= kw_q + 3'd1;
					end else begin
						kw_q <= KW_DEAD;
					end
				end
				position_q <= position_q + 1'b1;
			end else if (c == 8'h00) begin
				run_mode_q <= RUN_NONE;
				run_len_q  <= '0;
				kw_q       <= '0;
				position_q <= '0;
			end else if (letter || digit) begin
				run_start_q <= position_q;
				run_len_q   <= LEN_BITS'(1);
				run_mode_q  <= letter ? RUN_IDENT : RUN_NUMBER;
				kw_q        <= (c == kw_char(3'd0)) ? 3'd1 : KW_DEAD;
				position_q  <= position_q + 1'b1;
			end else begin
				run_mode_q <= RUN_NONE;
				run_len_q  <= '0;
				kw_q       <= '0;
				position_q <= position_q + 1'b1;
			end
		end
	end

endmodule

>>> src/exptok_queue.sv
// Short queue of token entries between front and back.
module exptok_queue
	import exptok_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  entry_t      push_entry,
	input  logic        pop,
	output entry_t      head,
	output queue_stat_t q_stat
);

	entry_t               mem_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_BITS:0]   count_q;
	logic                 do_push, do_pop;

	assign q_stat.full  = count_q == (QPTR_BITS+1)'(QUEUE_DEPTH);
	assign q_stat.valid = count_q != '0;
	assign do_push      = push && !q_stat.full;
	assign do_pop       = pop && q_stat.valid;
	assign head         = mem_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> src/exptok_back.sv
// Back: takes entries from the queue and sends their tokens one at a time.
module exptok_back
	import exptok_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  entry_t      head,
	input  queue_stat_t q_stat,
	output logic        pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [3:0] token_kind, [19:4] token_start,
	                               // [27:20] token_length, [31:28] zero
	output logic        m_tlast    // last
);

	entry_t ent_q;
	logic   ent_valid_q;
	logic   fire, done, load, send_flush;
	token_t tok;

	assign send_flush = ent_q.has_flush;
	assign tok        = send_flush ? ent_q.flush_tok : ent_q.cur_tok;
	assign m_tvalid   = ent_valid_q;
	assign m_tdata    = {4'b0000, tok.length, tok.start, tok.kind};
	assign m_tlast    = !send_flush || !ent_q.has_cur;

	assign fire = m_tvalid && m_tready;
	assign done = fire && m_tlast;
	assign load = !ent_valid_q || done;
	assign pop  = load && q_stat.valid;

	// Current entry and its remaining tokens
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_valid_q <= 1'b0;
		end else if (load) begin
			ent_valid_q <= q_stat.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ent_q <= head;
		end else if (fire) begin
			ent_q.has_flush <= 1'b0;
		end
	end

endmodule

>>> src/expression_tokenizer_top.sv
// Expression tokenizer: one character per item in, one token per item out.
// A token passes through the entry queue and the back's entry register before it is offered.
// One character per cycle while the queue has room; a character that both ends a run and
// gives a token of its own yields two tokens, absorbed by a four-entry queue.
// Reset (arst_n low, asynchronous) clears the run state, position and queue.
module expression_tokenizer_top
	import exptok_pkg::*;
#(
	parameter int POSITION_BITS = 16,
	parameter int MAX_TOKEN_LEN = 255
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] ch
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [3:0] token_kind, [19:4] token_start,
	                               // [27:20] token_length, [31:28] zero
	output logic        m_tlast    // last
);

	queue_stat_t q_stat;
	logic        push, pop;
	entry_t      push_entry, head;

	exptok_front #(
		.POSITION_BITS(POSITION_BITS),
		.MAX_TOKEN_LEN(MAX_TOKEN_LEN)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.q_stat     (q_stat),
		.push       (push),
		.push_entry (push_entry)
	);

	exptok_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.q_stat     (q_stat)
	);

	exptok_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.q_stat   (q_stat),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

>>> src/exptok_checker.sv
// Port-level checks for the expression tokenizer, bound to the top level.
`include "assert_macros.svh"

module exptok_assertions
	import exptok_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [7:0]  s_tdata,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tlast
);

	logic [3:0] kind;
	logic [7:0] length;
	logic       ch_single;

	assign kind      = m_tdata[3:0];
	assign length    = m_tdata[27:20];
	// an accepted operator or punctuation character
	assign ch_single = s_tvalid && s_tready && single_kind(s_tdata) != KIND_UNKNOWN;

	// a stalled token stays offered and unchanged
	`ASSERT_NEXT(a_hold_valid, clk, arst_n, m_tvalid && !m_tready, m_tvalid)
	`ASSERT_NEXT(a_hold_data, clk, arst_n, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tlast))
	// end of input is a zero-length token that closes its item
	`ASSERT_IMPLY(a_eoi_shape, clk, arst_n, m_tvalid && kind == KIND_EOI, length == 8'd0 && m_tlast)
	// operator and punctuation tokens are one character long and close their item
	`ASSERT_IMPLY(a_op_shape, clk, arst_n, m_tvalid && kind >= KIND_PLUS, length == 8'd1 && m_tlast)
	// an operator character accepted while no token is offered always yields some token
	`ASSERT_NEXT(a_op_reaches_out, clk, arst_n, ch_single && !m_tvalid, ##1 m_tvalid)

endmodule

bind expression_tokenizer_top exptok_assertions u_exptok_assertions (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
